FILE: hdl/stack_engine_with_search_unit_assert.svh
// assertion macros for the stack engine with search unit
`ifndef STACK_ENGINE_WITH_SEARCH_UNIT_ASSERT_SVH
`define STACK_ENGINE_WITH_SEARCH_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a condition in the following cycle
`define SES_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/ses_pkg.sv
// types and constants shared by the stack engine with search unit
package ses_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int MATCH_W     = 7;
    localparam int OCC_W       = 7;

    typedef enum logic [3:0] {
        OP_PUSH        = 4'd0,
        OP_POP         = 4'd1,
        OP_PEEK        = 4'd2,
        OP_MAX         = 4'd3,
        OP_MIN         = 4'd4,
        OP_FIND        = 4'd5,
        OP_REMOVE      = 4'd6,
        OP_REMOVE_THRU = 4'd7,
        OP_COUNT       = 4'd8,
        OP_CLEAR       = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [WORD_W-1:0] operand_value;
    } cmd_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] result_value;
        logic [MATCH_W-1:0]       match_position;
        logic [OCC_W-1:0]         occupancy;
    } res_item_t;

endpackage

FILE: hdl/ses_ram.sv
// generic simple dual-port ram with registered read
module ses_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/stack_engine_with_search_unit.sv
// top level of the stack engine with search unit
//
//  channel  | direction | payload      | handshake
//  ---------+-----------+--------------+------------------------
//  cmd      | in        | cmd_item_t   | cmd_valid / cmd_stall
//  res      | out       | res_item_t   | res_valid / res_stall
//
// push, pop, count, clear and refused operations need no ram read; peek reads the
// top entry. max and min read every entry; find and remove through match read from
// the top down to the match (the whole stack if none); remove of a match below the
// top adds a compaction pass that reads each entry above the match and writes it
// one place lower. the entry ram's single read port reads one entry per cycle.
// reset clears the entry count and the control state; the entry ram is not cleared.
// one result register: a new transaction is taken while a result waits,
// and a finished operation holds in its done state until the register frees.
module stack_engine_with_search_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ses_pkg::cmd_item_t cmd_data,
    output logic               res_valid,
    input  logic               res_stall,
    output ses_pkg::res_item_t res_data
);

    import ses_pkg::*;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [WORD_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        rd_addr_reg, rd_addr_next;
    logic                     issue_more_reg, issue_more_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]        rd_tag_reg, rd_tag_next;
    logic                     first_reg, first_next;
    status_t                  pend_status_reg, pend_status_next;
    logic signed [WORD_W-1:0] pend_value_reg, pend_value_next;
    logic [MATCH_W-1:0]       pend_pos_reg, pend_pos_next;
    logic                     res_valid_reg, res_valid_next;
    res_item_t                res_data_reg, res_data_next;

    logic                     cmd_accept;
    logic                     out_free;
    logic                     rd_en;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [WORD_W-1:0]        mem_wdata;
    logic [WORD_W-1:0]        mem_rdata;
    logic signed [WORD_W-1:0] rd_word;
    logic [ADDR_W-1:0]        top_idx;
    logic                     better;

    // entry storage
    ses_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    assign rd_word    = $signed(mem_rdata);
    assign top_idx    = ADDR_W'(count_reg - CNT_W'(1));
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    // running max / min compare
    always_comb
    begin
        if (op_reg == OP_MAX)
        begin
            better = first_reg || (rd_word > pend_value_reg);
        end
        else
        begin
            better = first_reg || (rd_word < pend_value_reg);
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        rd_addr_next     = rd_addr_reg;
        issue_more_next  = issue_more_reg;
        rd_vld_next      = 1'b0;
        rd_tag_next      = rd_tag_reg;
        first_next       = first_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        pend_pos_next    = pend_pos_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_data_next    = res_data_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ADDR_W'(count_reg);
        mem_wdata        = value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next          = cmd_data.operation;
                    value_next       = cmd_data.operand_value;
                    pend_status_next = ST_OK;
                    pend_value_next  = '0;
                    pend_pos_next    = '0;
                    first_next       = 1'b1;
                    state_next       = S_DONE;
                    case (cmd_data.operation)
                        OP_PUSH:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = ADDR_W'(count_reg);
                                mem_wdata  = cmd_data.operand_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_PEEK, OP_MAX, OP_MIN, OP_FIND, OP_REMOVE, OP_REMOVE_THRU:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next      = S_SCAN;
                                rd_addr_next    = top_idx;
                                issue_more_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // count and unused codes leave the stack alone
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // consume the word read last cycle
                if (rd_vld_reg)
                begin
                    case (op_reg)
                        OP_PEEK:
                        begin
                            pend_value_next = rd_word;
                            state_next      = S_DONE;
                        end
                        OP_MAX, OP_MIN:
                        begin
                            first_next = 1'b0;
                            if (better)
                            begin
                                pend_value_next = rd_word;
                            end
                            if (rd_tag_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            if (rd_word == value_reg)
                            begin
                                pend_pos_next = MATCH_W'(count_reg - CNT_W'(rd_tag_reg));
                                state_next    = S_DONE;
                                if (op_reg == OP_REMOVE_THRU)
                                begin
                                    count_next = CNT_W'(rd_tag_reg);
                                end
                                else if (op_reg == OP_REMOVE)
                                begin
                                    if (rd_tag_reg == top_idx)
                                    begin
                                        count_next = count_reg - CNT_W'(1);
                                    end
                                    else
                                    begin
                                        state_next      = S_SHIFT;
                                        rd_addr_next    = rd_tag_reg + ADDR_W'(1);
                                        issue_more_next = 1'b1;
                                    end
                                end
                            end
                            else if (rd_tag_reg == '0)
                            begin
                                pend_status_next = ST_NOTFOUND;
                                state_next       = S_DONE;
                            end
                        end
                    endcase
                end
                // issue the next read, top down
                if (state_next == S_SCAN && issue_more_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_tag_next = rd_addr_reg;
                    if (rd_addr_reg == '0)
                    begin
                        issue_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg - ADDR_W'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                // move each entry above the match down by one
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_tag_reg - ADDR_W'(1);
                    mem_wdata = mem_rdata;
                    if (rd_tag_reg == top_idx)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                // issue the next read, bottom up
                if (state_next == S_SHIFT && issue_more_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_tag_next = rd_addr_reg;
                    if (rd_addr_reg == top_idx)
                    begin
                        issue_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_data_next.status         = pend_status_reg;
                    res_data_next.result_value   = pend_value_reg;
                    res_data_next.match_position = pend_pos_reg;
                    res_data_next.occupancy      = OCC_W'(count_reg);
                    res_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_more_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_more_reg <= issue_more_next;
            rd_vld_reg     <= rd_vld_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        value_reg       <= value_next;
        rd_addr_reg     <= rd_addr_next;
        rd_tag_reg      <= rd_tag_next;
        first_reg       <= first_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        pend_pos_reg    <= pend_pos_next;
        res_data_reg    <= res_data_next;
    end

`include "stack_engine_with_search_unit_assert.svh"

    `SES_ASSERT(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "entry count above depth")
    `SES_ASSERT(a_no_rw_clash, !(mem_we && rd_en && mem_waddr == rd_addr_reg), "read write clash")
    `SES_ASSERT(a_rd_vld_state, rd_vld_reg |-> (state_reg == S_SCAN || state_reg == S_SHIFT),
                "read data outside scan")
    `SES_ASSERT_NEXT(a_accept_busy, cmd_valid && !cmd_stall, state_reg != S_IDLE,
                     "accepted transaction not started")

endmodule

FILE: tb/sv/tb_stack_engine_with_search_unit.sv
// self-checking testbench for the stack engine with search unit
`timescale 1ns / 100ps

module tb_stack_engine_with_search_unit;
    import ses_pkg::*;

    localparam int          RESET_CYCLES      = 11;
    localparam int          DRAIN_CYCLES      = 160;
    localparam int          LONG_HOLD_CYCLES  = 250;
    localparam int unsigned RUN_LIMIT_NS      = 12_000_000;
    localparam int          RANDOM_ITEMS      = 1040;

    // operation codes the block does not define
    localparam logic [3:0] FIRST_UNUSED_OP = 4'd10;
    localparam logic [3:0] LAST_OP_CODE    = 4'd15;

    localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] EDGE_VALUES [4] =
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_data;

    // shadow copy of the stack
    logic signed [WORD_W-1:0] shadow_entries [STACK_DEPTH];
    int                       shadow_depth = 0;

    res_item_t pending_results [$];
    int        mismatch_count = 0;

    // idling controls
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    int long_hold_req = 0;
    int hold_count    = 0;

    stack_engine_with_search_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // apply one operation to the shadow stack and return its outcome
    function automatic res_item_t predict_stack_op(input logic [3:0] code,
                                                   input logic signed [WORD_W-1:0] value);
        res_item_t                outcome;
        logic signed [WORD_W-1:0] extreme;
        int                       hit;
        outcome        = '0;
        outcome.status = ST_OK;
        hit            = -1;
        case (code)
            OP_PUSH:
                if (shadow_depth >= STACK_DEPTH)
                    outcome.status = ST_FULL;
                else
                begin
                    shadow_entries[shadow_depth] = value;
                    shadow_depth++;
                end
            OP_POP:
                if (shadow_depth == 0)
                    outcome.status = ST_EMPTY;
                else
                    shadow_depth--;
            OP_PEEK:
                if (shadow_depth == 0)
                    outcome.status = ST_EMPTY;
                else
                    outcome.result_value = shadow_entries[shadow_depth-1];
            OP_MAX, OP_MIN:
                if (shadow_depth == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    extreme = shadow_entries[shadow_depth-1];
                    for (int k = 0; k < shadow_depth; k++)
                    begin
                        if (code == OP_MAX ? shadow_entries[k] > extreme
                                           : shadow_entries[k] < extreme)
                            extreme = shadow_entries[k];
                    end
                    outcome.result_value = extreme;
                end
            OP_FIND, OP_REMOVE, OP_REMOVE_THRU:
                if (shadow_depth == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    // first match seen from the top
                    for (int k = shadow_depth - 1; k >= 0; k--)
                    begin
                        if (shadow_entries[k] == value)
                        begin
                            hit = k;
                            break;
                        end
                    end
                    if (hit < 0)
                        outcome.status = ST_NOTFOUND;
                    else
                    begin
                        outcome.match_position = MATCH_W'(shadow_depth - hit);
                        if (code == OP_REMOVE)
                        begin
                            for (int k = hit; k < shadow_depth - 1; k++)
                                shadow_entries[k] = shadow_entries[k+1];
                            shadow_depth--;
                        end
                        else if (code == OP_REMOVE_THRU)
                            shadow_depth = hit;
                    end
                end
            OP_CLEAR:
                shadow_depth = 0;
            default:
                ;
        endcase
        outcome.occupancy = OCC_W'(shadow_depth);
        return outcome;
    endfunction

    // operand mix: stored values, a small pool with duplicates, extremes, anything
    function automatic logic signed [WORD_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (shadow_depth != 0 && roll < 45)
            return shadow_entries[$urandom_range(0, shadow_depth - 1)];
        if (roll < 70)
            return 32'($urandom_range(0, 7)) - 32'd4;
        if (roll < 78)
            return EDGE_VALUES[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // sender idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_quiet || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one transaction, record its outcome once taken, then idle for a random gap, possibly none
    task automatic issue_cmd(input logic [3:0] code, input logic signed [WORD_W-1:0] value);
        int gap;
        cmd_valid <= 1'b1;
        cmd_data  <= cmd_item_t'({code, value});
        do
            @(posedge clk);
        while (cmd_stall);
        pending_results.push_back(predict_stack_op(code, value));
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver stall pattern, including a long hold on request
    always @(posedge clk)
    begin : result_stall_gen
        int roll;
        if (long_hold_req != 0)
        begin
            hold_count    = long_hold_req;
            long_hold_req = 0;
        end
        roll = $urandom_range(0, 99);
        if (hold_count != 0)
        begin
            hold_count--;
            res_stall <= 1'b1;
        end
        else if (rx_quiet || roll < 70)
            res_stall <= 1'b0;
        else if (roll < 95)
        begin
            hold_count = $urandom_range(0, 2);
            res_stall <= 1'b1;
        end
        else
        begin
            hold_count = $urandom_range(8, 30);
            res_stall <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input longint want, input longint seen);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
    endtask

    // compare every result transaction with the oldest outcome waiting
    always @(posedge clk)
    begin : result_check
        res_item_t want_res;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none expected, actual %h", $time, res_data);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (res_data.status !== want_res.status)
                    report_mismatch("status", want_res.status, res_data.status);
                if (res_data.result_value !== want_res.result_value)
                    report_mismatch("result_value", want_res.result_value,
                                    res_data.result_value);
                if (res_data.match_position !== want_res.match_position)
                    report_mismatch("match_position", want_res.match_position,
                                    res_data.match_position);
                if (res_data.occupancy !== want_res.occupancy)
                    report_mismatch("occupancy", want_res.occupancy, res_data.occupancy);
            end
        end
    end

    // every operation but push on an empty stack, plus undefined codes
    task automatic test_empty_stack();
        issue_cmd(OP_POP, 0);
        issue_cmd(OP_PEEK, 0);
        issue_cmd(OP_MAX, 0);
        issue_cmd(OP_MIN, 0);
        issue_cmd(OP_FIND, 5);
        issue_cmd(OP_REMOVE, 5);
        issue_cmd(OP_REMOVE_THRU, 5);
        issue_cmd(OP_COUNT, 0);
        issue_cmd(OP_CLEAR, 0);
        issue_cmd(FIRST_UNUSED_OP, MOST_POS);
        issue_cmd(LAST_OP_CODE, MOST_NEG);
    endtask

    // extreme values, duplicates, hits and misses, removal in the middle
    task automatic test_extreme_values();
        issue_cmd(OP_PUSH, MOST_NEG);
        issue_cmd(OP_PUSH, MOST_POS);
        issue_cmd(OP_PUSH, 0);
        issue_cmd(OP_PUSH, -1);
        issue_cmd(OP_PUSH, MOST_POS);
        issue_cmd(OP_MAX, 0);
        issue_cmd(OP_MIN, 0);
        issue_cmd(OP_PEEK, 0);
        issue_cmd(OP_FIND, MOST_POS);
        issue_cmd(OP_FIND, MOST_NEG);
        issue_cmd(OP_FIND, 7);
        issue_cmd(OP_REMOVE, 0);
        issue_cmd(OP_REMOVE_THRU, MOST_POS);
        issue_cmd(OP_COUNT, 0);
        issue_cmd(OP_CLEAR, 0);
    endtask

    // fill to the limit, refused pushes, deepest search and removal
    task automatic test_full_stack();
        logic signed [WORD_W-1:0] bottom;
        issue_cmd(OP_CLEAR, 0);
        while (shadow_depth < STACK_DEPTH)
            issue_cmd(OP_PUSH, pick_operand());
        issue_cmd(OP_PUSH, $urandom);
        issue_cmd(OP_PUSH, MOST_NEG);
        issue_cmd(OP_MAX, 0);
        issue_cmd(OP_MIN, 0);
        issue_cmd(OP_PEEK, 0);
        bottom = shadow_entries[0];
        issue_cmd(OP_FIND, bottom);
        issue_cmd(OP_REMOVE, bottom);
        issue_cmd(OP_COUNT, 0);
        while (shadow_depth < STACK_DEPTH)
            issue_cmd(OP_PUSH, $urandom);
        bottom = shadow_entries[0];
        issue_cmd(OP_REMOVE_THRU, bottom);
        issue_cmd(OP_COUNT, 0);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_result_backpressure();
        tx_quiet      = 1'b1;
        long_hold_req = LONG_HOLD_CYCLES;
        for (int n = 0; n < 30; n++)
            issue_cmd(4'($urandom_range(int'(OP_PUSH), int'(OP_COUNT))), pick_operand());
        tx_quiet = 1'b0;
    endtask

    // random walk of the fill level, mostly shallow, with searches that hit
    task automatic test_random_mix(input int n_items);
        int         level_goal;
        int         roll;
        logic [3:0] code;
        level_goal = 4;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    level_goal = $urandom_range(0, 12);
                else if (roll < 95)
                    level_goal = $urandom_range(13, 40);
                else
                    level_goal = $urandom_range(41, STACK_DEPTH + 2);
            end
            // stretches with no idling on one side or the other
            if (n % 60 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                code = 4'($urandom_range(FIRST_UNUSED_OP, LAST_OP_CODE));
            else if (roll < 5)
                code = OP_CLEAR;
            else if (shadow_depth < level_goal && roll < 55)
                code = OP_PUSH;
            else if (shadow_depth > level_goal && roll < 40)
                code = OP_POP;
            else
                code = 4'($urandom_range(int'(OP_PUSH), int'(OP_COUNT)));
            issue_cmd(code, pick_operand());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_extreme_values();
        test_full_stack();
        test_result_backpressure();
        test_random_mix(RANDOM_ITEMS);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ses_pkg.sv
hdl/ses_ram.sv
hdl/stack_engine_with_search_unit.sv
tb/sv/tb_stack_engine_with_search_unit.sv
